>>> hw/rtl/hcgv_pkg.sv
package hcgv_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned DIM_CFG_W  = 11;
  localparam int unsigned SAT_W      = 8;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CLASS_W    = 3;
  localparam int unsigned CELL_W     = 4;

  // Grid and counter store geometry.
  localparam int unsigned NUM_CLASSES = 6;
  localparam int unsigned NUM_CELLS   = 9;
  localparam int unsigned NUM_COUNTS  = NUM_CLASSES * NUM_CELLS;
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned SUB_W       = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_THRESH   = 2'd2;

  // Register values after reset.
  localparam logic [DIM_CFG_W-1:0] FRAME_WIDTH_RST  = 11'd384;
  localparam logic [DIM_CFG_W-1:0] FRAME_HEIGHT_RST = 11'd384;
  localparam logic [SAT_W-1:0]     SAT_THRESH_RST   = 8'd50;

  // Hue band edges on the half-degree scale.
  localparam logic [PIX_W-1:0] HUE_GREEN_LO  = 8'd46;
  localparam logic [PIX_W-1:0] HUE_GREEN_HI  = 8'd99;
  localparam logic [PIX_W-1:0] HUE_YELLOW_LO = 8'd22;
  localparam logic [PIX_W-1:0] HUE_YELLOW_HI = 8'd45;
  localparam logic [PIX_W-1:0] HUE_ORANGE_LO = 8'd8;
  localparam logic [PIX_W-1:0] HUE_RED_LO    = 8'd8;
  localparam logic [PIX_W-1:0] HUE_RED2_LO   = 8'd151;
  localparam logic [PIX_W-1:0] HUE_MAX       = 8'd180;
  localparam logic [PIX_W-1:0] HUE_BLUE_HI   = 8'd150;

  typedef enum logic [CLASS_W-1:0] {
    CLS_NONE   = 3'd0,
    CLS_GREEN  = 3'd1,
    CLS_RED    = 3'd2,
    CLS_BLUE   = 3'd3,
    CLS_YELLOW = 3'd4,
    CLS_WHITE  = 3'd5,
    CLS_ORANGE = 3'd6
  } hcgv_class_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pix_take;
    logic pix_update;
    logic vote_start;
    logic vote_step;
    logic vote_emit;
  } hcgv_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic frame_end;
    logic sub_done;
    logic cell_last;
  } hcgv_status_t;

  // Classify one pixel; the first matching band wins.
  function automatic logic [CLASS_W-1:0] classify(input logic [PIX_W-1:0] hue,
                                                  input logic [SAT_W-1:0] sat,
                                                  input logic [SAT_W-1:0] thr);
    logic [CLASS_W-1:0] cls;
    if (sat < thr) begin
      cls = CLS_WHITE;
    end else if (hue > HUE_GREEN_LO && hue < HUE_GREEN_HI) begin
      cls = CLS_GREEN;
    end else if (hue >= HUE_YELLOW_LO && hue < HUE_YELLOW_HI) begin
      cls = CLS_YELLOW;
    end else if (hue >= HUE_ORANGE_LO && hue < HUE_YELLOW_LO) begin
      cls = CLS_ORANGE;
    end else if (hue <= HUE_RED_LO || (hue >= HUE_RED2_LO && hue <= HUE_MAX)) begin
      cls = CLS_RED;
    end else if (hue >= HUE_GREEN_HI && hue < HUE_BLUE_HI) begin
      cls = CLS_BLUE;
    end else begin
      cls = CLS_NONE;
    end
    return cls;
  endfunction

endpackage

>>> hw/rtl/hcgv_if.sv
// Pixel input channel.
interface hcgv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;

  modport source (output valid, output hue, output saturation, input ready);
  modport sink (input valid, input hue, input saturation, output ready);
endinterface

// Result output channel.
interface hcgv_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [2:0] pixel_class;
  logic [3:0] cell_index;
  logic [2:0] cell_color;
  logic       last;

  modport source (output valid, output kind, output pixel_class, output cell_index,
                  output cell_color, output last, input ready);
  modport sink (input valid, input kind, input pixel_class, input cell_index,
                input cell_color, input last, output ready);
endinterface

>>> hw/rtl/hcgv_datapath.sv
module hcgv_datapath import hcgv_pkg::*; #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [PIX_W-1:0]      hue_i,
  input  logic [PIX_W-1:0]      saturation_i,
  input  logic                  out_ready_i,
  input  hcgv_cmd_t             cmd_i,
  output hcgv_status_t          status_o,
  output logic                  out_valid_o,
  output logic                  kind_o,
  output logic [CLASS_W-1:0]    pixel_class_o,
  output logic [CELL_W-1:0]     cell_index_o,
  output logic [CLASS_W-1:0]    cell_color_o,
  output logic                  last_o
);

  localparam int unsigned POS_W = $clog2(MAX_DIM);
  localparam int unsigned DIM_W = $clog2(MAX_DIM + 1);
  localparam int unsigned EXT_W = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
  localparam int unsigned T_W   = DIM_W + 2;

  // Configuration registers.
  logic [DIM_CFG_W-1:0] width_q, height_q;
  logic [SAT_W-1:0]     thr_q;

  // Frame position and per-pixel pipeline registers.
  logic [POS_W-1:0]  col_q, row_q;
  logic [ADDR_W-1:0] addr_q;
  logic              cls_nz_q;
  logic              frame_end_q;

  // Counter store, its valid bits and the registered read port.
  logic [COUNT_BITS-1:0] mem_q [NUM_COUNTS];
  logic [NUM_COUNTS-1:0] vld_q;
  logic [COUNT_BITS-1:0] rdata_q;
  logic                  rvld_q;

  // Vote sequencing.
  logic [CELL_W-1:0]     cell_q;
  logic [SUB_W-1:0]      sub_q;
  logic [CLASS_W-1:0]    best_q;
  logic [COUNT_BITS-1:0] best_cnt_q;

  // Output register.
  logic                  out_valid_q;
  logic                  kind_q;
  logic [CLASS_W-1:0]    pixel_class_q;
  logic [CELL_W-1:0]     cell_index_q;
  logic [CLASS_W-1:0]    cell_color_q;
  logic                  last_q;

  logic [DIM_W-1:0]      w_eff, h_eff;
  logic [CLASS_W-1:0]    pix_cls;
  logic [1:0]            col_third, row_third;
  logic [CELL_W-1:0]     pix_cell;
  logic [ADDR_W-1:0]     pix_addr, vote_addr, rd_addr;
  logic                  rd_en;
  logic                  col_end, row_end;
  logic [COUNT_BITS-1:0] cur_cnt;
  logic                  out_free;

  // Clamp a configured dimension to the supported range.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] v);
    logic [EXT_W-1:0] ext;
    logic [DIM_W-1:0] res;
    ext = EXT_W'(v);
    if (ext < EXT_W'(3)) begin
      res = DIM_W'(3);
    end else if (ext > EXT_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(ext);
    end
    return res;
  endfunction

  // Which third a position falls in: pos < dim/3 exactly when 3*(pos+1) <= dim.
  function automatic logic [1:0] third_of(input logic [POS_W-1:0] pos,
                                          input logic [DIM_W-1:0] dim);
    logic [T_W-1:0] p1, t3;
    logic [1:0]     res;
    p1 = T_W'(pos) + T_W'(1);
    t3 = p1 + (p1 << 1);
    if (t3 <= T_W'(dim)) begin
      res = 2'd0;
    end else if (t3 <= (T_W'(dim) << 1)) begin
      res = 2'd1;
    end else begin
      res = 2'd2;
    end
    return res;
  endfunction

  assign w_eff = clamp_dim(width_q);
  assign h_eff = clamp_dim(height_q);

  // Pixel class, its cell and its counter address.
  assign pix_cls   = classify(hue_i, saturation_i, thr_q);
  assign col_third = third_of(col_q, w_eff);
  assign row_third = third_of(row_q, h_eff);
  assign pix_cell  = (CELL_W'(row_third) << 1) + CELL_W'(row_third) + CELL_W'(col_third);
  assign pix_addr  = (ADDR_W'(pix_cell) << 2) + (ADDR_W'(pix_cell) << 1)
                   + ADDR_W'(pix_cls - 3'd1);
  assign vote_addr = (ADDR_W'(cell_q) << 2) + (ADDR_W'(cell_q) << 1) + ADDR_W'(sub_q);

  // Row and frame ends.
  assign col_end = DIM_W'(col_q) >= (w_eff - DIM_W'(1));
  assign row_end = DIM_W'(row_q) >= (h_eff - DIM_W'(1));

  // Read port shared between pixel updates and the vote pass.
  assign rd_en   = cmd_i.pix_take || (cmd_i.vote_step && sub_q != SUB_W'(NUM_CLASSES));
  assign rd_addr = cmd_i.pix_take ? pix_addr : vote_addr;
  assign cur_cnt = rvld_q ? rdata_q : '0;

  assign out_free = !out_valid_q || out_ready_i;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
      thr_q    <= SAT_THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i[DIM_CFG_W-1:0];
        REG_FRAME_HEIGHT: height_q <= cfg_data_i[DIM_CFG_W-1:0];
        REG_SAT_THRESH:   thr_q    <= cfg_data_i[SAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Position tracking, advanced on each accepted pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      frame_end_q <= 1'b0;
    end else if (cmd_i.pix_take) begin
      frame_end_q <= col_end && row_end;
      if (col_end) begin
        col_q <= '0;
        row_q <= row_end ? '0 : row_q + POS_W'(1);
      end else begin
        col_q <= col_q + POS_W'(1);
      end
    end
  end

  // Pixel pipeline payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_take) begin
      addr_q   <= pix_addr;
      cls_nz_q <= pix_cls != CLS_NONE;
    end
  end

  // Counter store: registered read, saturating increment on write-back.
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
      rvld_q  <= vld_q[rd_addr];
    end
    if (cmd_i.pix_update && cls_nz_q && cur_cnt != '1) begin
      mem_q[addr_q] <= cur_cnt + COUNT_BITS'(1);
    end
  end

  // Valid bits: an entry not yet written this frame reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (cmd_i.vote_emit && cell_q == CELL_W'(NUM_CELLS - 1)) begin
      vld_q <= '0;
    end else if (cmd_i.pix_update && cls_nz_q) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  // Vote pass: read six counts of a cell and keep the first strict maximum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q     <= '0;
      sub_q      <= '0;
      best_q     <= CLS_NONE;
      best_cnt_q <= '0;
    end else if (cmd_i.vote_start) begin
      cell_q     <= '0;
      sub_q      <= '0;
      best_q     <= CLS_NONE;
      best_cnt_q <= '0;
    end else if (cmd_i.vote_step) begin
      sub_q <= sub_q + SUB_W'(1);
      if (sub_q != '0 && cur_cnt > best_cnt_q) begin
        best_q     <= CLASS_W'(sub_q);
        best_cnt_q <= cur_cnt;
      end
    end else if (cmd_i.vote_emit) begin
      cell_q     <= cell_q + CELL_W'(1);
      sub_q      <= '0;
      best_q     <= CLS_NONE;
      best_cnt_q <= '0;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.pix_take || cmd_i.vote_emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_take) begin
      kind_q        <= 1'b0;
      pixel_class_q <= pix_cls;
      cell_index_q  <= '0;
      cell_color_q  <= CLS_NONE;
      last_q        <= 1'b0;
    end else if (cmd_i.vote_emit) begin
      kind_q        <= 1'b1;
      pixel_class_q <= CLS_NONE;
      cell_index_q  <= cell_q;
      cell_color_q  <= best_q;
      last_q        <= cell_q == CELL_W'(NUM_CELLS - 1);
    end
  end

  assign status_o.out_free  = out_free;
  assign status_o.frame_end = frame_end_q;
  assign status_o.sub_done  = sub_q == SUB_W'(NUM_CLASSES);
  assign status_o.cell_last = cell_q == CELL_W'(NUM_CELLS - 1);

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign pixel_class_o = pixel_class_q;
  assign cell_index_o  = cell_index_q;
  assign cell_color_o  = cell_color_q;
  assign last_o        = last_q;

endmodule

>>> hw/rtl/hcgv_ctrl.sv
module hcgv_ctrl import hcgv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  input  hcgv_status_t status_i,
  output logic         in_ready_o,
  output hcgv_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_UPDATE   = 2'd1;
  localparam logic [1:0] ST_VOTE_RD  = 2'd2;
  localparam logic [1:0] ST_VOTE_OUT = 2'd3;

  logic [1:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = status_i.out_free;
        cmd_o.pix_take = in_valid_i && status_i.out_free;
        if (cmd_o.pix_take) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.pix_update = 1'b1;
        if (status_i.frame_end) begin
          cmd_o.vote_start = 1'b1;
          state_d          = ST_VOTE_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_VOTE_RD: begin
        cmd_o.vote_step = 1'b1;
        if (status_i.sub_done) begin
          state_d = ST_VOTE_OUT;
        end
      end
      ST_VOTE_OUT: begin
        cmd_o.vote_emit = status_i.out_free;
        if (status_i.out_free) begin
          state_d = status_i.cell_last ? ST_IDLE : ST_VOTE_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> hw/rtl/hsv_color_grid_vote_core.sv
// HSV colour classifier with a 3x3 grid vote.
// Pixels (hue, saturation) enter on in_i in raster order; every accepted item
// gives one pixel result on out_o, and the last pixel of a frame is followed by
// nine cell verdicts, the ninth flagged by last.
// Frame size and saturation threshold are written through the cfg_* port while
// the block is idle; the user must keep to this, as the block does not enforce it.
// Latency: a pixel result is presented in the cycle after its item is accepted.
// Each pixel takes a read and a write-back of the single-port counter store,
// and no new item is accepted until its write-back is done. After the last
// pixel of a frame the vote pass makes, for each cell, six reads through the
// store, one compare and one output step, waiting while the receiver stalls;
// no item is accepted during the pass.
// Reset sets the frame to 384 by 384 and the threshold to 50; all counts read as
// zero at once through per-entry valid bits, with no clearing pass.
// When the receiver stalls, the output register holds its item and in_i.ready
// stays low until the register can take the next result.
module hsv_color_grid_vote_core import hcgv_pkg::*; #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  hcgv_in_if.sink               in_i,
  hcgv_out_if.source            out_o
);

  hcgv_cmd_t    cmd;
  hcgv_status_t status;

  // Controller.
  hcgv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd)
  );

  // Datapath with the counter store and output register.
  hcgv_datapath #(
    .MAX_DIM    (MAX_DIM),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .hue_i         (in_i.hue),
    .saturation_i  (in_i.saturation),
    .out_ready_i   (out_o.ready),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (out_o.valid),
    .kind_o        (out_o.kind),
    .pixel_class_o (out_o.pixel_class),
    .cell_index_o  (out_o.cell_index),
    .cell_color_o  (out_o.cell_color),
    .last_o        (out_o.last)
  );

  // An item is only taken when the output register can hold its result.
  a_take_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!out_o.valid || out_o.ready))
    else $error("item accepted while output register full");

  // Every accepted item shows its pixel result in the next cycle.
  a_pixel_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (out_o.valid && !out_o.kind))
    else $error("pixel result missing after accepted item");

  // The frame flag only marks the verdict of the last cell.
  a_last_on_final_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (out_o.kind && out_o.cell_index == 4'd8))
    else $error("last flag on a result other than the final verdict");

  // No new item is taken while a vote pass is running.
  a_no_take_in_vote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.vote_step || cmd.vote_emit) |-> !in_i.ready)
    else $error("input ready during vote pass");

endmodule
